@@ rtl/hkua_pkg.sv @@
// ----------------------------------------------------------------------------
// hkua_pkg
// Types and constants shared by the hashed key usage accumulator modules.
// ----------------------------------------------------------------------------
package hkua_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned TOT_W  = 64;
  localparam int unsigned SLOT_W = 7;

  localparam logic ACT_ACCUM = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FULL = 1'b1;

  typedef struct packed {
    logic              action;
    logic [KEY_W-1:0]  group_key;
    logic [TOT_W-1:0]  amount;
    logic [SLOT_W-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic              entry_valid;
    logic [KEY_W-1:0]  entry_key;
    logic [TOT_W-1:0]  entry_total;
  } out_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [TOT_W-1:0] total;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_REDUCE,
    S_FOLD,
    S_PROBE,
    S_FETCH,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic clr;
    logic load;
    logic lookup;
    logic mul;
    logic reduce;
    logic fold;
    logic step;
    logic commit_acc;
    logic commit_full;
    logic commit_read;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_read;
    logic hit;
    logic empty;
    logic last_probe;
    logic out_busy;
  } sts_t;

endpackage

@@ rtl/hashed_key_usage_accumulator.sv @@
// ----------------------------------------------------------------------------
// hashed_key_usage_accumulator
// Open-addressing table of running totals keyed by group, linear probing.
// ----------------------------------------------------------------------------
// accumulate: after acceptance the HASH, REDUCE and FOLD states, then k probes (1 to TABLE_SLOTS),
//   one slot examined per cycle through the single read port of the slot memory, then EMIT
// read of one slot: after acceptance the FETCH state, then EMIT
// next word is taken once the result has moved into the output register
// after reset a clearing pass writes every slot empty before the first word
module hashed_key_usage_accumulator import hkua_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  hkua_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hkua_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ rtl/hkua_ctrl.sv @@
// ----------------------------------------------------------------------------
// hkua_ctrl
// Sequencer for clearing, hashing, probing, slot reads and result hand-off.
// ----------------------------------------------------------------------------
module hkua_ctrl import hkua_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_read) begin
            cmd_o.lookup = 1'b1;
            state_d      = S_FETCH;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        cmd_o.mul = 1'b1;
        state_d   = S_REDUCE;
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        state_d      = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = S_PROBE;
      end
      S_PROBE: begin
        if (sts_i.hit || sts_i.empty) begin
          cmd_o.commit_acc = 1'b1;
          state_d          = S_EMIT;
        end else if (sts_i.last_probe) begin
          cmd_o.commit_full = 1'b1;
          state_d           = S_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_FETCH: begin
        cmd_o.commit_read = 1'b1;
        state_d           = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/hkua_dp.sv @@
// ----------------------------------------------------------------------------
// hkua_dp
// Slot memory, home slot hash, probe pointer, totals adder and output word.
// ----------------------------------------------------------------------------
module hkua_dp import hkua_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 128,
  localparam int unsigned IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  input  logic out_ready_i,
  output logic out_valid_o,
  output out_t out_data_o,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam logic [KEY_W-1:0] RECIP   = KEY_W'((64'd1 << KEY_W) / TABLE_SLOTS);
  localparam logic [KEY_W-1:0] N_KEY   = KEY_W'(TABLE_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(TABLE_SLOTS - 1);

  entry_t             mem [TABLE_SLOTS];
  entry_t             rd_q;
  in_t                item_q;
  logic [2*KEY_W-1:0] prod_q;
  logic [KEY_W-1:0]   qn_q;
  logic [IDX_W-1:0]   p_q, cnt_q, clr_q;
  out_t               res_q, out_q;
  logic               out_valid_q;

  logic [IDX_W-1:0] p_next, home, rd_addr, wr_addr;
  logic [KEY_W-1:0] diff, rem;
  logic [TOT_W-1:0] sum;
  logic             wr_en, in_range;
  entry_t           wr_data;

  // home slot: key minus an estimated multiple of the table size, one fix-up
  assign diff   = item_q.group_key - qn_q;
  assign rem    = (diff >= N_KEY) ? diff - N_KEY : diff;
  assign home   = IDX_W'(rem);
  assign p_next = (p_q == LAST_IX) ? '0 : p_q + 1'b1;
  assign sum    = rd_q.total + item_q.amount;
  assign in_range = KEY_W'(item_q.slot_index) < N_KEY;

  always_comb begin
    if (cmd_i.lookup) begin
      rd_addr = IDX_W'(in_data_i.slot_index);
    end else if (cmd_i.fold) begin
      rd_addr = home;
    end else if (cmd_i.step) begin
      rd_addr = p_next;
    end else begin
      rd_addr = p_q;
    end
  end

  always_comb begin
    wr_en   = cmd_i.clr | cmd_i.commit_acc;
    wr_addr = cmd_i.clr ? clr_q : p_q;
    wr_data = '0;
    if (cmd_i.commit_acc) begin
      wr_data.valid = 1'b1;
      wr_data.key   = item_q.group_key;
      wr_data.total = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      prod_q <= item_q.group_key * RECIP;
    end
    if (cmd_i.reduce) begin
      qn_q <= KEY_W'(prod_q[2*KEY_W-1:KEY_W] * N_KEY);
    end
    if (cmd_i.fold) begin
      p_q   <= home;
      cnt_q <= '0;
    end else if (cmd_i.step) begin
      p_q   <= p_next;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.commit_acc) begin
      res_q <= '{status: ST_OK, slot: SLOT_W'(p_q), entry_valid: 1'b1,
                 entry_key: item_q.group_key, entry_total: sum};
    end else if (cmd_i.commit_full) begin
      res_q <= '{status: ST_FULL, default: '0};
    end else if (cmd_i.commit_read) begin
      if (in_range && rd_q.valid) begin
        res_q <= '{status: ST_OK, slot: item_q.slot_index, entry_valid: 1'b1,
                   entry_key: rd_q.key, entry_total: rd_q.total};
      end else begin
        res_q <= '{status: ST_OK, slot: item_q.slot_index, default: '0};
      end
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.clr_last   = (clr_q == LAST_IX);
  assign sts_o.in_read    = (in_data_i.action == ACT_READ);
  assign sts_o.hit        = rd_q.valid && (rd_q.key == item_q.group_key);
  assign sts_o.empty      = !rd_q.valid;
  assign sts_o.last_probe = (cnt_q == LAST_IX);
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
